/* hw/rtl/grid_maze_dfs_path_finder_defines.svh */
// Assertion macros used by the grid maze path finder datapath.
`ifndef GRID_MAZE_DFS_PATH_FINDER_DEFINES_SVH
`define GRID_MAZE_DFS_PATH_FINDER_DEFINES_SVH

// Same-cycle implication, clocked on clk_i and disabled during reset.
`define GMDFS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gmdfs check failed");

// Next-cycle implication, clocked on clk_i and disabled during reset.
`define GMDFS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gmdfs check failed");

`endif

/* hw/rtl/gmdfs_pkg.sv */
// Types, constants and control structs of the grid maze path finder.
package gmdfs_pkg;

  localparam int unsigned SIDE_DEF = 5;
  localparam int unsigned COORD_W  = 3;
  localparam int unsigned IDX_W    = 7;
  localparam int unsigned LEN_W    = 7;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // Search directions, tried in this order.
  localparam logic [2:0] DIR_PX  = 3'd0;
  localparam logic [2:0] DIR_PY  = 3'd1;
  localparam logic [2:0] DIR_PZ  = 3'd2;
  localparam logic [2:0] DIR_NX  = 3'd3;
  localparam logic [2:0] DIR_NY  = 3'd4;
  localparam logic [2:0] DIR_NZ  = 3'd5;
  localparam logic [2:0] DIR_END = 3'd6;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_SOLVE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    op_e              opcode;
    coord_t           cell_x;
    coord_t           cell_y;
    coord_t           cell_z;
    logic             cell_open;
    logic [IDX_W-1:0] step_index;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] path_length;
    coord_t           step_x;
    coord_t           step_y;
    coord_t           step_z;
  } out_item_t;

  // One search stack entry: cell and the next direction to try.
  typedef struct packed {
    logic [2:0] dir;
    coord_t     z;
    coord_t     y;
    coord_t     x;
  } stk_ent_t;

  typedef struct packed {
    logic init_sweep;
    logic clr_sweep;
    logic cell_wr;
    logic solve_init;
    logic rd_start;
    logic emit;
    logic emit_step;
    logic probe;
    logic try_dir;
    logic save_top;
    logic visit;
    logic pop;
    logic pop_load;
    logic end_push;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic dir_end;
    logic nb_inside;
    logic nb_far;
    logic cell_free;
    logic depth_zero;
    logic depth_one;
  } sts_t;

endpackage

/* hw/rtl/gmdfs_ctrl.sv */
// Sequencing state machine of the grid maze path finder.
module gmdfs_ctrl import gmdfs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  op_e  opcode_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RD,
    S_CLR,
    S_START,
    S_CHK,
    S_TRY,
    S_POP,
    S_END,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        cmd_o.init_sweep = 1'b1;
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          case (opcode_i)
            OP_WRITE: begin
              cmd_o.cell_wr = 1'b1;
              cmd_o.emit    = 1'b1;
            end
            OP_SOLVE: begin
              cmd_o.solve_init = 1'b1;
              state_d          = S_CLR;
            end
            OP_READ: begin
              cmd_o.rd_start = 1'b1;
              state_d        = S_RD;
            end
            default: begin
              cmd_o.emit = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_step = 1'b1;
        state_d         = S_IDLE;
      end
      S_CLR: begin
        cmd_o.clr_sweep = 1'b1;
        if (sts_i.sweep_last) state_d = S_START;
      end
      S_START: begin
        cmd_o.probe = 1'b1;
        state_d     = S_CHK;
      end
      S_CHK: begin
        if (sts_i.cell_free) begin
          cmd_o.visit    = 1'b1;
          cmd_o.save_top = !sts_i.depth_zero;
          state_d        = S_TRY;
        end else if (sts_i.depth_zero) begin
          state_d = S_DONE;
        end else begin
          state_d = S_TRY;
        end
      end
      S_TRY: begin
        if (sts_i.dir_end) begin
          cmd_o.pop = 1'b1;
          state_d   = sts_i.depth_one ? S_DONE : S_POP;
        end else begin
          cmd_o.try_dir = 1'b1;
          if (sts_i.nb_far) begin
            cmd_o.save_top = 1'b1;
            state_d        = S_END;
          end else if (sts_i.nb_inside) begin
            state_d = S_CHK;
          end
        end
      end
      S_POP: begin
        cmd_o.pop_load = 1'b1;
        state_d        = S_TRY;
      end
      S_END: begin
        cmd_o.end_push = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

/* hw/rtl/gmdfs_dp.sv */
// Datapath of the grid maze path finder: maze, visited marks, stack, result.
module gmdfs_dp import gmdfs_pkg::*; #(
  parameter int unsigned SIDE = SIDE_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  in_item_t  item_i,
  output sts_t      sts_o,
  output logic      res_strobe_o,
  output out_item_t result_o
);

  `include "grid_maze_dfs_path_finder_defines.svh"

  localparam int unsigned CELLS = SIDE * SIDE * SIDE;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned DW    = $clog2(CELLS + 1);
  localparam int unsigned CMPW  = (DW > IDX_W) ? DW : IDX_W;
  localparam coord_t LAST = coord_t'(SIDE - 1);
  localparam logic [COORD_W:0] SIDE_X = (COORD_W + 1)'(SIDE);
  localparam logic [COORD_W:0] ONE_X  = (COORD_W + 1)'(1);

  function automatic logic [AW-1:0] cell_idx(input coord_t x, input coord_t y,
                                             input coord_t z);
    logic [15:0] t;
    t = (16'(z) * 16'(SIDE) + 16'(y)) * 16'(SIDE) + 16'(x);
    return t[AW-1:0];
  endfunction

  logic     maze_mem [CELLS];
  logic     vis_mem  [CELLS];
  stk_ent_t stk_mem  [CELLS];

  logic [AW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] d_q, d_d;
  logic          found_q, found_d;
  stk_ent_t      top_q, top_d;
  logic          strobe_q;

  stk_ent_t      nb_q;
  logic [AW-1:0] nb_idx_q;
  logic          hit_q;
  logic          maze_rd_q, vis_rd_q;
  stk_ent_t      stk_rd_q;
  out_item_t     res_q;

  stk_ent_t      nb_d;
  logic          nb_inside, nb_far;
  logic [AW-1:0] rd_cell, wr_idx;
  logic          wr_ok, sweep_last, room;
  logic          stk_we;
  logic [AW-1:0] stk_wa, stk_ra;
  stk_ent_t      stk_wd;

  // Neighbor of the top cell in its current direction.
  always_comb begin
    nb_d      = top_q;
    nb_d.dir  = '0;
    nb_inside = 1'b1;
    case (top_q.dir)
      DIR_PX: begin
        nb_d.x    = top_q.x + coord_t'(1);
        nb_inside = ({1'b0, top_q.x} + ONE_X) < SIDE_X;
      end
      DIR_PY: begin
        nb_d.y    = top_q.y + coord_t'(1);
        nb_inside = ({1'b0, top_q.y} + ONE_X) < SIDE_X;
      end
      DIR_PZ: begin
        nb_d.z    = top_q.z + coord_t'(1);
        nb_inside = ({1'b0, top_q.z} + ONE_X) < SIDE_X;
      end
      DIR_NX: begin
        nb_d.x    = top_q.x - coord_t'(1);
        nb_inside = (top_q.x != '0);
      end
      DIR_NY: begin
        nb_d.y    = top_q.y - coord_t'(1);
        nb_inside = (top_q.y != '0);
      end
      DIR_NZ: begin
        nb_d.z    = top_q.z - coord_t'(1);
        nb_inside = (top_q.z != '0);
      end
      default: begin
        nb_inside = 1'b0;
      end
    endcase
  end

  assign nb_far = nb_inside && (nb_d.x == LAST) && (nb_d.y == LAST) && (nb_d.z == LAST);
  assign rd_cell = cmd_i.probe ? '0 : cell_idx(nb_d.x, nb_d.y, nb_d.z);
  assign wr_idx  = cell_idx(item_i.cell_x, item_i.cell_y, item_i.cell_z);
  assign wr_ok   = ({1'b0, item_i.cell_x} < SIDE_X) && ({1'b0, item_i.cell_y} < SIDE_X) &&
                   ({1'b0, item_i.cell_z} < SIDE_X);
  assign sweep_last = (cnt_q == AW'(CELLS - 1));
  assign room       = (d_q < DW'(CELLS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_sweep) begin
      maze_mem[cnt_q] <= 1'b1;
    end else if (cmd_i.cell_wr && wr_ok) begin
      maze_mem[wr_idx] <= item_i.cell_open;
    end
    maze_rd_q <= maze_mem[rd_cell];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_sweep || cmd_i.clr_sweep) begin
      vis_mem[cnt_q] <= 1'b0;
    end else if (cmd_i.visit) begin
      vis_mem[nb_idx_q] <= 1'b1;
    end
    vis_rd_q <= vis_mem[rd_cell];
  end

  // Stack port: the top entry lives in top_q and is written back on a push.
  always_comb begin
    stk_we = 1'b0;
    stk_wa = AW'(d_q - DW'(1));
    stk_wd = top_q;
    if (cmd_i.save_top) begin
      stk_we = 1'b1;
      if (cmd_i.try_dir) stk_wd.dir = top_q.dir + 3'd1;
    end else if (cmd_i.end_push) begin
      stk_we = room;
      stk_wa = AW'(d_q);
      stk_wd = nb_q;
    end
  end

  assign stk_ra = cmd_i.pop ? AW'(d_q - DW'(2)) : AW'(item_i.step_index);

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd_q <= stk_mem[stk_ra];
  end

  always_comb begin
    cnt_d   = cnt_q;
    d_d     = d_q;
    found_d = found_q;
    top_d   = top_q;
    if (cmd_i.init_sweep || cmd_i.clr_sweep) begin
      cnt_d = sweep_last ? '0 : cnt_q + AW'(1);
    end
    if (cmd_i.solve_init) begin
      cnt_d   = '0;
      d_d     = '0;
      found_d = 1'b0;
    end
    if (cmd_i.try_dir) top_d.dir = top_q.dir + 3'd1;
    if (cmd_i.visit && room) begin
      d_d   = d_q + DW'(1);
      top_d = nb_q;
    end
    if (cmd_i.pop) d_d = d_q - DW'(1);
    if (cmd_i.pop_load) top_d = stk_rd_q;
    if (cmd_i.end_push) begin
      found_d = 1'b1;
      if (room) d_d = d_q + DW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      d_q      <= '0;
      found_q  <= 1'b0;
      top_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      d_q      <= d_d;
      found_q  <= found_d;
      top_q    <= top_d;
      strobe_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe) begin
      nb_q     <= '0;
      nb_idx_q <= '0;
    end else if (cmd_i.try_dir) begin
      nb_q     <= nb_d;
      nb_idx_q <= rd_cell;
    end
    if (cmd_i.rd_start) begin
      hit_q <= CMPW'(item_i.step_index) < CMPW'(d_q);
    end
    if (cmd_i.emit) begin
      res_q.found       <= found_q;
      res_q.path_length <= (CMPW'(d_q) > CMPW'(LEN_MAX)) ? LEN_MAX : LEN_W'(d_q);
      if (cmd_i.emit_step && hit_q) begin
        res_q.step_x <= stk_rd_q.x;
        res_q.step_y <= stk_rd_q.y;
        res_q.step_z <= stk_rd_q.z;
      end else begin
        res_q.step_x <= '0;
        res_q.step_y <= '0;
        res_q.step_z <= '0;
      end
    end
  end

  assign sts_o.sweep_last = sweep_last;
  assign sts_o.dir_end    = (top_q.dir >= DIR_END);
  assign sts_o.nb_inside  = nb_inside;
  assign sts_o.nb_far     = nb_far;
  assign sts_o.cell_free  = maze_rd_q && !vis_rd_q;
  assign sts_o.depth_zero = (d_q == '0);
  assign sts_o.depth_one  = (d_q == DW'(1));

  assign res_strobe_o = strobe_q;
  assign result_o     = res_q;

  `GMDFS_ASSERT_IMP(a_depth_bound, 1'b1, d_q <= DW'(CELLS))
  `GMDFS_ASSERT_IMP(a_dir_range, 1'b1, top_q.dir <= DIR_END)
  `GMDFS_ASSERT_IMP(a_found_has_path, found_q, d_q != '0)
  `GMDFS_ASSERT_IMP(a_pop_nonempty, cmd_i.pop, d_q != '0)
  `GMDFS_ASSERT_NXT(a_pop_shrinks, cmd_i.pop, d_q == $past(d_q) - DW'(1))

endmodule

/* hw/rtl/grid_maze_dfs_path_finder.sv */
// Top level of the 3-D grid maze depth-first path finder.
//
//   channel | direction | handshake                    | payload
//   --------+-----------+------------------------------+------------------------
//   command | in        | start high while busy is low | item_i  (in_item_t)
//   result  | out       | res_strobe_o for one cycle   | result_o (out_item_t)
//
// A write beat and an unused opcode finish in S_IDLE, with the result strobed in the
// next cycle. A read beat goes through S_RD since the stack memory has a registered
// read port. A solve beat first clears the visited marks, one cell per cycle, then
// tries each direction (neighbor address in S_TRY, then the registered maze and
// visited read in S_CHK, which is skipped when the neighbor lies outside the cube)
// and passes through S_POP on each backtrack. After reset the block sweeps the whole
// maze open with busy held high. The result side cannot stall; every beat yields
// exactly one result.
module grid_maze_dfs_path_finder import gmdfs_pkg::*; #(
  parameter int unsigned SIDE = SIDE_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item_i,
  output logic      res_strobe_o,
  output out_item_t result_o
);

  // The controller only sees status flags; all storage sits in the datapath.
  cmd_t cmd;
  sts_t sts;

  gmdfs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (item_i.opcode),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // The datapath keeps the maze, the visited marks, the search stack with its top
  // entry in registers, and the output register that drives the result beat.
  gmdfs_dp #(
    .SIDE (SIDE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .item_i       (item_i),
    .sts_o        (sts),
    .res_strobe_o (res_strobe_o),
    .result_o     (result_o)
  );

endmodule

/* tb/gmdfs_path_checker.sv */
// Scoreboard for the grid maze path finder: predicts each result beat and compares it.
module gmdfs_path_checker import gmdfs_pkg::*; #(
  parameter int unsigned SIDE = SIDE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  in_item_t    item_i,
  input  logic        res_strobe_i,
  input  out_item_t   result_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o,
  output int unsigned path_len_o,
  output int unsigned exits_found_o,
  output int unsigned longest_path_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CELLS = SIDE * SIDE * SIDE;

  logic        cell_open_q [CELLS];
  logic        visited_q   [CELLS];
  stk_ent_t    trail_q     [CELLS];
  int unsigned trail_depth;
  logic        exit_found_q;
  out_item_t   expected_beats [$];

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned exits_found;
  int unsigned longest_path;

  assign mismatch_cnt_o = mismatch_cnt;
  assign pending_o      = pending_cnt;
  assign path_len_o     = trail_depth;
  assign exits_found_o  = exits_found;
  assign longest_path_o = longest_path;

  function automatic int unsigned cell_idx(input int unsigned x, y, z);
    return (z * SIDE + y) * SIDE + x;
  endfunction

  function automatic void push_trail(input int unsigned x, y, z);
    if (trail_depth < CELLS) begin
      trail_q[trail_depth] = '{dir: DIR_PX, z: coord_t'(z), y: coord_t'(y), x: coord_t'(x)};
      trail_depth++;
    end
  endfunction

  // Depth-first search with an explicit stack. Whatever is left on the stack
  // after a successful search is the path.
  function automatic void search_maze();
    stk_ent_t    top_e;
    int unsigned nx, ny, nz, c;
    logic        in_cube;
    foreach (visited_q[i]) visited_q[i] = 1'b0;
    trail_depth  = 0;
    exit_found_q = 1'b0;
    if (!cell_open_q[0]) return;
    visited_q[0] = 1'b1;
    push_trail(0, 0, 0);
    while (trail_depth > 0) begin
      top_e = trail_q[trail_depth-1];
      if (top_e.dir >= DIR_END) begin
        trail_depth--;
        continue;
      end
      trail_q[trail_depth-1].dir = top_e.dir + 3'd1;
      nx = top_e.x;
      ny = top_e.y;
      nz = top_e.z;
      case (top_e.dir)
        DIR_PX: begin
          nx = top_e.x + 1;
          in_cube = nx < SIDE;
        end
        DIR_PY: begin
          ny = top_e.y + 1;
          in_cube = ny < SIDE;
        end
        DIR_PZ: begin
          nz = top_e.z + 1;
          in_cube = nz < SIDE;
        end
        DIR_NX: begin
          in_cube = top_e.x > 0;
          nx = top_e.x - 1;
        end
        DIR_NY: begin
          in_cube = top_e.y > 0;
          ny = top_e.y - 1;
        end
        default: begin
          in_cube = top_e.z > 0;
          nz = top_e.z - 1;
        end
      endcase
      // Stepping onto the far corner wins, wall or not.
      if (in_cube && nx == SIDE-1 && ny == SIDE-1 && nz == SIDE-1) begin
        push_trail(nx, ny, nz);
        exit_found_q = 1'b1;
        return;
      end
      if (!in_cube) continue;
      c = cell_idx(nx, ny, nz);
      if (!cell_open_q[c] || visited_q[c]) continue;
      visited_q[c] = 1'b1;
      push_trail(nx, ny, nz);
    end
    trail_depth = 0;
  endfunction

  function automatic out_item_t predict_beat(input in_item_t cmd);
    out_item_t res;
    stk_ent_t  ent;
    res = '0;
    case (cmd.opcode)
      OP_WRITE: begin
        if (cmd.cell_x < SIDE && cmd.cell_y < SIDE && cmd.cell_z < SIDE)
          cell_open_q[cell_idx(cmd.cell_x, cmd.cell_y, cmd.cell_z)] = cmd.cell_open;
      end
      OP_SOLVE: begin
        search_maze();
        if (exit_found_q) begin
          exits_found++;
          if (trail_depth > longest_path) longest_path = trail_depth;
        end
      end
      OP_READ: begin
        if (cmd.step_index < trail_depth && cmd.step_index < CELLS) begin
          ent = trail_q[cmd.step_index];
          res.step_x = ent.x;
          res.step_y = ent.y;
          res.step_z = ent.z;
        end
      end
      default: ;
    endcase
    res.found       = exit_found_q;
    res.path_length = (trail_depth > LEN_MAX) ? LEN_MAX : LEN_W'(trail_depth);
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned want, got);
    if (want != got) begin
      mismatch_cnt++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    out_item_t want;
    if (!rst_ni) begin
      foreach (cell_open_q[i]) cell_open_q[i] = 1'b1;
      foreach (visited_q[i]) visited_q[i] = 1'b0;
      foreach (trail_q[i]) trail_q[i] = '0;
      trail_depth  = 0;
      exit_found_q = 1'b0;
      expected_beats.delete();
      mismatch_cnt = 0;
      exits_found  = 0;
      longest_path = 0;
    end else begin
      // Results first, so a stray result never pairs with a command taken at this edge.
      if (res_strobe_i) begin
        if (expected_beats.size() == 0) begin
          mismatch_cnt++;
          $error("result beat with no command outstanding");
        end else begin
          want = expected_beats.pop_front();
          check_field("found", want.found, result_i.found);
          check_field("path_length", want.path_length, result_i.path_length);
          check_field("step_x", want.step_x, result_i.step_x);
          check_field("step_y", want.step_y, result_i.step_y);
          check_field("step_z", want.step_z, result_i.step_z);
        end
      end
      if (start_i && !busy_i) begin
        expected_beats.insert(expected_beats.size(), predict_beat(item_i));
      end
    end
    pending_cnt = expected_beats.size();
  end

endmodule

/* tb/tb.sv */
// Top of the grid maze path finder testbench: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gmdfs_pkg::*;

  localparam int unsigned SIDE         = SIDE_DEF;
  localparam int unsigned ITEMS        = 700;
  localparam int unsigned DRAIN_CYCLES = 16;
  // This covers every beat being a worst-case solve plus the longest idle
  // gaps, several times over.
  localparam longint unsigned WATCHDOG_NS = 40_000_000;

  // Opcode 3 has no meaning in the block; it must answer with status only.
  localparam op_e OP_UNUSED = op_e'(2'd3);

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  logic      busy;
  in_item_t  item_i = '0;
  logic      res_strobe_o;
  out_item_t result_o;

  int unsigned mismatch_cnt;
  int unsigned pending;
  int unsigned path_len;
  int unsigned exits_found;
  int unsigned longest_path;

  // Beat tallies for the closing summary. Out-of-cube writes and the unused
  // opcode change nothing, so they do not count toward the item budget.
  int unsigned n_writes;
  int unsigned n_solves;
  int unsigned n_reads;
  int unsigned n_unused;
  int unsigned n_useful;

  // When set, the sender issues beats back to back with no idle cycles.
  logic burst_mode = 1'b0;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  grid_maze_dfs_path_finder #(
    .SIDE (SIDE)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .item_i       (item_i),
    .res_strobe_o (res_strobe_o),
    .result_o     (result_o)
  );

  // The checker watches both channels, keeps its own copy of the maze and the
  // search stack, and reports how many results are still owed.
  gmdfs_path_checker #(
    .SIDE (SIDE)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .item_i         (item_i),
    .res_strobe_i   (res_strobe_o),
    .result_i       (result_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending),
    .path_len_o     (path_len),
    .exits_found_o  (exits_found),
    .longest_path_o (longest_path)
  );

  // Every field random, the opcode included; used as noise and as filler for
  // the fields that a given opcode ignores.
  function automatic in_item_t random_beat();
    in_item_t b;
    b.opcode     = op_e'($urandom_range(0, 3));
    b.cell_x     = coord_t'($urandom);
    b.cell_y     = coord_t'($urandom);
    b.cell_z     = coord_t'($urandom);
    b.cell_open  = 1'($urandom);
    b.step_index = IDX_W'($urandom);
    return b;
  endfunction

  function automatic in_item_t beat_of(input op_e op, input int unsigned x, y, z,
                                       input logic open, input int unsigned idx);
    in_item_t b;
    b.opcode     = op;
    b.cell_x     = coord_t'(x);
    b.cell_y     = coord_t'(y);
    b.cell_z     = coord_t'(z);
    b.cell_open  = open;
    b.step_index = IDX_W'(idx);
    return b;
  endfunction

  // Mostly inside the cube; now and then past its edge, up to the field's top.
  function automatic coord_t pick_coord();
    if ($urandom_range(0, 99) < 95) return coord_t'($urandom_range(0, SIDE-1));
    return coord_t'($urandom_range(SIDE, 7));
  endfunction

  function automatic in_item_t write_beat(input int unsigned open_pct);
    in_item_t b;
    b = random_beat();
    b.opcode    = OP_WRITE;
    b.cell_x    = pick_coord();
    b.cell_y    = pick_coord();
    b.cell_z    = pick_coord();
    b.cell_open = ($urandom_range(0, 99) < open_pct);
    return b;
  endfunction

  function automatic in_item_t solve_beat();
    in_item_t b;
    b = random_beat();
    b.opcode = OP_SOLVE;
    return b;
  endfunction

  // Reads aim mostly inside the current path, sometimes just past its end,
  // sometimes anywhere in the index field.
  function automatic in_item_t read_beat();
    in_item_t    b;
    int unsigned r;
    b = random_beat();
    b.opcode = OP_READ;
    r = $urandom_range(0, 99);
    if (path_len > 0 && r < 70) b.step_index = IDX_W'($urandom_range(0, path_len - 1));
    else if (r < 85)            b.step_index = IDX_W'(path_len);
    else                        b.step_index = IDX_W'($urandom_range(0, 127));
    return b;
  endfunction

  // Called at a falling edge. Holds the beat until the block takes it, then
  // idles for a random gap unless burst mode is on. Returns at a falling edge.
  task automatic send_beat(input in_item_t beat);
    int unsigned r, gap;
    item_i <= beat;
    start  <= 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    case (beat.opcode)
      OP_WRITE: begin
        n_writes++;
        if (beat.cell_x < SIDE && beat.cell_y < SIDE && beat.cell_z < SIDE) n_useful++;
      end
      OP_SOLVE: begin
        n_solves++;
        n_useful++;
      end
      OP_READ: begin
        n_reads++;
        n_useful++;
      end
      default: n_unused++;
    endcase
    if (burst_mode) return;
    r = $urandom_range(0, 99);
    if (r < 55)      gap = 0;
    else if (r < 88) gap = $urandom_range(1, 3);
    else             gap = $urandom_range(8, 60);
    if (gap == 0) return;
    start  <= 1'b0;
    item_i <= random_beat();
    repeat (gap) @(negedge clk_i);
  endtask

  // Stop sending until every expected result beat has come back.
  task automatic drain_results();
    if (start) start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned r, n, open_pct;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. After reset every cell is open, so the search runs
    // straight along +x, +y, +z and the path is 3 * (SIDE-1) + 1 cells.
    send_beat(beat_of(OP_SOLVE, 0, 0, 0, 1'b0, 0));
    send_beat(beat_of(OP_READ, 0, 0, 0, 1'b0, 0));
    send_beat(beat_of(OP_READ, 0, 0, 0, 1'b0, 3 * (SIDE-1)));
    // Just past the end of the path, then the top of the index field.
    send_beat(beat_of(OP_READ, 0, 0, 0, 1'b0, 3 * (SIDE-1) + 1));
    send_beat(beat_of(OP_READ, 7, 7, 7, 1'b1, 127));
    send_beat(beat_of(OP_UNUSED, 7, 7, 7, 1'b1, 127));

    // A wall on the start cell makes the search fail at once.
    send_beat(beat_of(OP_WRITE, 0, 0, 0, 1'b0, 0));
    send_beat(beat_of(OP_SOLVE, 0, 0, 0, 1'b0, 0));
    send_beat(beat_of(OP_READ, 0, 0, 0, 1'b0, 0));

    // A wall on the far corner does not stop success.
    send_beat(beat_of(OP_WRITE, 0, 0, 0, 1'b1, 0));
    send_beat(beat_of(OP_WRITE, SIDE-1, SIDE-1, SIDE-1, 1'b0, 0));
    send_beat(beat_of(OP_SOLVE, 0, 0, 0, 1'b0, 0));

    // Writes outside the cube, one coordinate at a time, must be dropped.
    send_beat(beat_of(OP_WRITE, SIDE, 0, 0, 1'b0, 0));
    send_beat(beat_of(OP_WRITE, 0, 6, 0, 1'b0, 0));
    send_beat(beat_of(OP_WRITE, 0, 0, 7, 1'b0, 0));
    send_beat(beat_of(OP_SOLVE, 0, 0, 0, 1'b0, 0));

    // Changing the maze leaves the stored path alone until the next solve.
    send_beat(beat_of(OP_WRITE, 1, 0, 0, 1'b0, 0));
    send_beat(beat_of(OP_READ, 0, 0, 0, 1'b0, 1));
    send_beat(beat_of(OP_SOLVE, 0, 0, 0, 1'b0, 0));
    send_beat(beat_of(OP_READ, 0, 0, 0, 1'b0, 1));

    // Seal the exit: the search visits every reachable cell and fails.
    send_beat(beat_of(OP_WRITE, SIDE-2, SIDE-1, SIDE-1, 1'b0, 0));
    send_beat(beat_of(OP_WRITE, SIDE-1, SIDE-2, SIDE-1, 1'b0, 0));
    send_beat(beat_of(OP_WRITE, SIDE-1, SIDE-1, SIDE-2, 1'b0, 0));
    send_beat(beat_of(OP_SOLVE, 0, 0, 0, 1'b0, 0));
    send_beat(beat_of(OP_WRITE, SIDE-2, SIDE-1, SIDE-1, 1'b1, 0));
    send_beat(beat_of(OP_WRITE, SIDE-1, SIDE-2, SIDE-1, 1'b1, 0));
    send_beat(beat_of(OP_WRITE, SIDE-1, SIDE-1, SIDE-2, 1'b1, 0));
    drain_results();

    // Random part. Most scenarios edit a few cells, solve, then read back
    // parts of the path; the rest are noise and out-of-order sequences.
    while (n_useful < ITEMS) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 78) begin
        open_pct = $urandom_range(45, 97);
        n = $urandom_range(1, 12);
        repeat (n) send_beat(write_beat(open_pct));
        if ($urandom_range(0, 9) == 0) drain_results();
        send_beat(solve_beat());
        n = $urandom_range(1, 6);
        repeat (n) send_beat(read_beat());
      end else if (r < 90) begin
        n = $urandom_range(1, 5);
        repeat (n) send_beat(random_beat());
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            // Reads of a stale path after the maze moved under it.
            n = $urandom_range(1, 3);
            repeat (n) send_beat(write_beat(50));
            repeat (n) send_beat(read_beat());
          end
          1: begin
            send_beat(solve_beat());
            send_beat(solve_beat());
            send_beat(read_beat());
          end
          default: begin
            send_beat(beat_of(OP_UNUSED, $urandom, $urandom, $urandom, 1'($urandom),
                              $urandom));
            send_beat(read_beat());
          end
        endcase
      end
    end
    burst_mode = 1'b0;
    if (start) start <= 1'b0;

    // Wait for the last results, then watch a little longer for strays.
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d cell writes, %0d solves, %0d path reads and %0d unused-opcode beats.",
             n_writes, n_solves, n_reads, n_unused);
    $display("%0d solves reached the far corner; the longest path held %0d cells.",
             exits_found, longest_path);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("grid_maze_dfs_path_finder regression: pass");
    end else begin
      $display("grid_maze_dfs_path_finder regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("grid_maze_dfs_path_finder regression: fail");
    $finish;
  end

endmodule
